// ===== rtl/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants of the top-k sorted insert table
// Entry layout, action codes and memory control for the core and its store.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

  localparam int DEF_NUM_TABLES = 4;
  localparam int DEF_ENTRIES    = 8;

  localparam int ACT_W   = 2;
  localparam int SEL_W   = 2;
  localparam int SCORE_W = 31;
  localparam int TAG_W   = 16;
  localparam int SLOT_W  = 3;
  localparam int PLACE_W = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tks_store.sv =====
// ----------------------------------------------------------------------------
// tks_store: entry memory of all tables
// One write and one registered read per cycle; after reset a sweep writes
// every entry to zero and reports busy until it is done.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_store #(
  parameter int DEPTH = tks_pkg::DEF_NUM_TABLES * tks_pkg::DEF_ENTRIES,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CLRW = $clog2(DEPTH + 1)
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire tks_pkg::mem_ctl_t ctl,
  input  wire [AW-1:0]           waddr,
  input  wire tks_pkg::entry_t   wdata,
  input  wire [AW-1:0]           raddr,
  output tks_pkg::entry_t        rdata,
  output logic                   busy
);

  tks_pkg::entry_t mem [DEPTH];
  tks_pkg::entry_t rdata_r;
  logic [CLRW-1:0] clr_cnt_r;
  logic            we_eff;
  logic [AW-1:0]   waddr_eff;
  tks_pkg::entry_t wdata_eff;

  assign busy = clr_cnt_r < CLRW'(DEPTH);

  // clearing sweep owns the write port while busy
  always_comb begin
    if (busy) begin
      we_eff    = 1'b1;
      waddr_eff = clr_cnt_r[AW-1:0];
      wdata_eff = '0;
    end else begin
      we_eff    = ctl.we;
      waddr_eff = waddr;
      wdata_eff = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (busy) begin
      clr_cnt_r <= clr_cnt_r + CLRW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we_eff) begin
      mem[waddr_eff] <= wdata_eff;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/top_k_sorted_insert_table_core.sv =====
// insert and query walk the addressed table one slot a cycle through a single
// memory read port and one shared score comparator; a read goes through the
// states ST_RD, ST_RDW and ST_FIN.
// one transaction at a time; the next may be accepted while a result waits.
// after reset a clearing pass zeroes all entries, with in_stall high throughout.
// ----------------------------------------------------------------------------
// top_k_sorted_insert_table_core: bank of descending-sorted top-k tables
// Insert with shift-down, qualification query and entry read per table.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_sorted_insert_table_core #(
  parameter int NUM_TABLES = tks_pkg::DEF_NUM_TABLES,
  parameter int ENTRIES    = tks_pkg::DEF_ENTRIES
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [tks_pkg::ACT_W-1:0]     in_action,
  input  wire [tks_pkg::SEL_W-1:0]     in_table_sel,
  input  wire [tks_pkg::SCORE_W-1:0]   in_score_in,
  input  wire [tks_pkg::TAG_W-1:0]     in_tag_in,
  input  wire [tks_pkg::SLOT_W-1:0]    in_slot_in,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_qualifies,
  output logic [tks_pkg::PLACE_W-1:0]  out_placed_slot,
  output logic [tks_pkg::SCORE_W-1:0]  out_score_out,
  output logic [tks_pkg::TAG_W-1:0]    out_tag_out
);

  localparam int DEPTH = NUM_TABLES * ENTRIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam logic [tks_pkg::PLACE_W-1:0] NO_SLOT = tks_pkg::PLACE_W'(ENTRIES);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_RD   = 5'b00100,
    ST_RDW  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  tks_pkg::action_t             op_r, op_nxt;
  logic [AW-1:0]                base_r, base_nxt;
  logic [tks_pkg::SCORE_W-1:0]  sc_r, sc_nxt;
  logic [tks_pkg::SLOT_W-1:0]   sl_r, sl_nxt;
  tks_pkg::entry_t              carry_r, carry_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [SW-1:0]                ds_r, ds_nxt;
  logic                         rv_r, rv_nxt;
  logic                         found_r, found_nxt;

  logic                         res_q_r, res_q_nxt;
  logic [tks_pkg::PLACE_W-1:0]  res_slot_r, res_slot_nxt;
  logic [tks_pkg::SCORE_W-1:0]  res_score_r, res_score_nxt;
  logic [tks_pkg::TAG_W-1:0]    res_tag_r, res_tag_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_q_r, out_q_nxt;
  logic [tks_pkg::PLACE_W-1:0]  out_slot_r, out_slot_nxt;
  logic [tks_pkg::SCORE_W-1:0]  out_score_r, out_score_nxt;
  logic [tks_pkg::TAG_W-1:0]    out_tag_r, out_tag_nxt;

  tks_pkg::mem_ctl_t            mctl;
  logic [AW-1:0]                waddr;
  tks_pkg::entry_t              wdata;
  logic [AW-1:0]                raddr;
  tks_pkg::entry_t              rdata;
  logic                         clr_busy;

  logic                         in_acc;
  logic                         tb_ok;
  logic                         sl_ok;
  logic                         hit;
  logic                         last_slot;

  tks_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata),
    .busy  (clr_busy)
  );

  assign in_stall  = (state_r != ST_IDLE) || clr_busy;
  assign in_acc    = in_valid && !in_stall;
  assign tb_ok     = 32'(in_table_sel) < NUM_TABLES;
  assign sl_ok     = 32'(in_slot_in) < ENTRIES;

  // the one shared comparator
  assign hit       = sc_r >= rdata.score;
  assign last_slot = ds_r == SW'(ENTRIES - 1);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    base_nxt      = base_r;
    sc_nxt        = sc_r;
    sl_nxt        = sl_r;
    carry_nxt     = carry_r;
    cnt_nxt       = cnt_r;
    ds_nxt        = ds_r;
    rv_nxt        = 1'b0;
    found_nxt     = found_r;
    res_q_nxt     = res_q_r;
    res_slot_nxt  = res_slot_r;
    res_score_nxt = res_score_r;
    res_tag_nxt   = res_tag_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_q_nxt     = out_q_r;
    out_slot_nxt  = out_slot_r;
    out_score_nxt = out_score_r;
    out_tag_nxt   = out_tag_r;
    mctl          = '0;
    waddr         = base_r + AW'(ds_r);
    wdata         = carry_r;
    raddr         = base_r + AW'(cnt_r[SW-1:0]);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt        = tks_pkg::action_t'(in_action);
          base_nxt      = AW'(32'(in_table_sel) * ENTRIES);
          sc_nxt        = in_score_in;
          sl_nxt        = in_slot_in;
          carry_nxt     = '{score: in_score_in, tag: in_tag_in};
          cnt_nxt       = '0;
          found_nxt     = 1'b0;
          res_q_nxt     = 1'b0;
          res_slot_nxt  = NO_SLOT;
          res_score_nxt = '0;
          res_tag_nxt   = '0;
          if (!tb_ok) begin
            state_nxt = ST_FIN;
          end else begin
            case (tks_pkg::action_t'(in_action))
              tks_pkg::ACT_INSERT, tks_pkg::ACT_QUERY: state_nxt = ST_WALK;
              tks_pkg::ACT_READ: state_nxt = sl_ok ? ST_RD : ST_FIN;
              default: state_nxt = ST_FIN;
            endcase
          end
        end
      end
      ST_WALK: begin
        // read slot cnt while the data of slot ds is compared and rewritten
        if (cnt_r < CW'(ENTRIES)) begin
          mctl.re = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          rv_nxt  = 1'b1;
          ds_nxt  = cnt_r[SW-1:0];
        end
        if (rv_r) begin
          if (op_r == tks_pkg::ACT_INSERT) begin
            // from the first hit on, every slot takes the one above it
            if (found_r || hit) begin
              mctl.we   = 1'b1;
              carry_nxt = rdata;
            end
            if (hit && !found_r) begin
              found_nxt    = 1'b1;
              res_q_nxt    = 1'b1;
              res_slot_nxt = tks_pkg::PLACE_W'(ds_r);
            end
          end else if (hit) begin
            res_q_nxt = 1'b1;
          end
          if (last_slot) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_RD: begin
        mctl.re   = 1'b1;
        raddr     = base_r + AW'(sl_r);
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        res_score_nxt = rdata.score;
        res_tag_nxt   = rdata.tag;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = res_q_r;
          out_slot_nxt  = res_slot_r;
          out_score_nxt = res_score_r;
          out_tag_nxt   = res_tag_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    base_r      <= base_nxt;
    sc_r        <= sc_nxt;
    sl_r        <= sl_nxt;
    carry_r     <= carry_nxt;
    cnt_r       <= cnt_nxt;
    ds_r        <= ds_nxt;
    found_r     <= found_nxt;
    res_q_r     <= res_q_nxt;
    res_slot_r  <= res_slot_nxt;
    res_score_r <= res_score_nxt;
    res_tag_r   <= res_tag_nxt;
    out_q_r     <= out_q_nxt;
    out_slot_r  <= out_slot_nxt;
    out_score_r <= out_score_nxt;
    out_tag_r   <= out_tag_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_qualifies   = out_q_r;
  assign out_placed_slot = out_slot_r;
  assign out_score_out   = out_score_r;
  assign out_tag_out     = out_tag_r;

  // no transaction enters during the clearing sweep
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> in_stall)
    else $error("input accepted during clearing sweep");

  // an insert only writes inside its own table
  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (mctl.we && !clr_busy) |->
      (32'(waddr) >= 32'(base_r)) && (32'(waddr) < 32'(base_r) + ENTRIES))
    else $error("write outside addressed table");

  // query and read never modify the store
  a_no_write_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r != tks_pkg::ACT_INSERT && state_r != ST_IDLE) |-> !mctl.we)
    else $error("store written by a non-insert transaction");

  // a new result appears only out of the finish state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && out_stall)) |-> (state_r == ST_FIN))
    else $error("result loaded outside finish state");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the top-k sorted insert table core
// Directed rows and ~1950 random transactions go through the core. Each
// result is checked field by field against its row's typed result or a
// ranking model kept for each table. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import tks_pkg::*;

  localparam int NT         = DEF_NUM_TABLES;
  localparam int NE         = DEF_ENTRIES;
  localparam int RAND_ITEMS = 1950;
  localparam int TAIL_CYCLES = 4 * (NE + 3);
  localparam logic [PLACE_W-1:0] NOT_PLACED = PLACE_W'(NE);

  typedef struct packed {
    logic               qualifies;
    logic [PLACE_W-1:0] placed;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } rank_result_t;

  typedef struct packed {
    action_t            act;
    logic [SEL_W-1:0]   sel;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic [SLOT_W-1:0]  slot;
    logic               typed;
    rank_result_t       res;
  } stim_row_t;

  localparam logic [SCORE_W-1:0] SMAX = {SCORE_W{1'b1}};
  localparam logic [TAG_W-1:0]   TMAX = {TAG_W{1'b1}};

  // rows with typed = 0 are checked against the ranking model
  localparam stim_row_t DIRECTED [22] = '{
    '{ACT_READ,   2'd0, '0,     '0,        3'd0, 1'b1, '{1'b0, NOT_PLACED, '0, '0}},
    '{ACT_READ,   2'd3, SMAX,   TMAX,      3'd7, 1'b1, '{1'b0, NOT_PLACED, '0, '0}},
    '{ACT_QUERY,  2'd1, '0,     '0,        3'd0, 1'b1, '{1'b1, NOT_PLACED, '0, '0}},
    '{ACT_INSERT, 2'd0, SMAX,   TMAX,      3'd0, 1'b1, '{1'b1, 4'd0, '0, '0}},
    '{ACT_READ,   2'd0, '0,     '0,        3'd0, 1'b1, '{1'b0, NOT_PLACED, SMAX, TMAX}},
    // equal score goes ahead of the stored one
    '{ACT_INSERT, 2'd0, SMAX,   16'h1234,  3'd5, 1'b1, '{1'b1, 4'd0, '0, '0}},
    '{ACT_READ,   2'd0, '0,     '0,        3'd1, 1'b1, '{1'b0, NOT_PLACED, SMAX, TMAX}},
    '{ACT_INSERT, 2'd0, '0,     '0,        3'd0, 1'b1, '{1'b1, 4'd2, '0, '0}},
    '{ACT_NONE,   2'd2, SMAX,   TMAX,      3'd7, 1'b1, '{1'b0, NOT_PLACED, '0, '0}},
    '{ACT_QUERY,  2'd0, SMAX,   '0,        3'd0, 1'b1, '{1'b1, NOT_PLACED, '0, '0}},
    // fill table 1 with descending scores
    '{ACT_INSERT, 2'd1, 31'd800, 16'hA000, 3'd0, 1'b0, '0},
    '{ACT_INSERT, 2'd1, 31'd700, 16'hA001, 3'd0, 1'b0, '0},
    '{ACT_INSERT, 2'd1, 31'd600, 16'hA002, 3'd0, 1'b0, '0},
    '{ACT_INSERT, 2'd1, 31'd500, 16'hA003, 3'd0, 1'b0, '0},
    '{ACT_INSERT, 2'd1, 31'd400, 16'hA004, 3'd0, 1'b0, '0},
    '{ACT_INSERT, 2'd1, 31'd300, 16'hA005, 3'd0, 1'b0, '0},
    '{ACT_INSERT, 2'd1, 31'd200, 16'hA006, 3'd0, 1'b0, '0},
    '{ACT_INSERT, 2'd1, 31'd100, 16'hA007, 3'd0, 1'b0, '0},
    // full table, score below every entry
    '{ACT_INSERT, 2'd1, 31'd50,  16'hBEEF, 3'd0, 1'b1, '{1'b0, NOT_PLACED, '0, '0}},
    '{ACT_QUERY,  2'd1, 31'd50,  '0,       3'd0, 1'b1, '{1'b0, NOT_PLACED, '0, '0}},
    '{ACT_QUERY,  2'd1, 31'd100, '0,       3'd0, 1'b1, '{1'b1, NOT_PLACED, '0, '0}},
    '{ACT_READ,   2'd1, '0,      '0,       3'd7, 1'b1, '{1'b0, NOT_PLACED, 31'd100, 16'hA007}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ACT_W-1:0]     in_action = '0;
  logic [SEL_W-1:0]     in_table_sel = '0;
  logic [SCORE_W-1:0]   in_score_in = '0;
  logic [TAG_W-1:0]     in_tag_in = '0;
  logic [SLOT_W-1:0]    in_slot_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_qualifies;
  logic [PLACE_W-1:0]   out_placed_slot;
  logic [SCORE_W-1:0]   out_score_out;
  logic [TAG_W-1:0]     out_tag_out;

  logic [SCORE_W-1:0]   rank_score [NT][NE];
  logic [TAG_W-1:0]     rank_tag   [NT][NE];
  rank_result_t         pending_results [$];
  rank_result_t         seen_exp, seen_got;
  int                   err_count = 0;
  bit                   calm = 1'b0;

  top_k_sorted_insert_table_core #(
    .NUM_TABLES (NT),
    .ENTRIES    (NE)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_table_sel    (in_table_sel),
    .in_score_in     (in_score_in),
    .in_tag_in       (in_tag_in),
    .in_slot_in      (in_slot_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_qualifies   (out_qualifies),
    .out_placed_slot (out_placed_slot),
    .out_score_out   (out_score_out),
    .out_tag_out     (out_tag_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ranking model: applies one transaction to its tables and gives the result
  task automatic rank_apply(input action_t act, input logic [SEL_W-1:0] sel,
                            input logic [SCORE_W-1:0] sc, input logic [TAG_W-1:0] tg,
                            input logic [SLOT_W-1:0] sl, output rank_result_t r);
    int pos;
    r = '{1'b0, NOT_PLACED, '0, '0};
    if (int'(sel) < NT) begin
      pos = NE;
      for (int i = NE - 1; i >= 0; i--) begin
        if (sc >= rank_score[sel][i]) pos = i;
      end
      case (act)
        ACT_INSERT: begin
          if (pos < NE) begin
            for (int j = NE - 1; j > pos; j--) begin
              rank_score[sel][j] = rank_score[sel][j-1];
              rank_tag[sel][j]   = rank_tag[sel][j-1];
            end
            rank_score[sel][pos] = sc;
            rank_tag[sel][pos]   = tg;
            r.qualifies = 1'b1;
            r.placed    = PLACE_W'(pos);
          end
        end
        ACT_QUERY: r.qualifies = (pos < NE);
        ACT_READ: begin
          if (int'(sl) < NE) begin
            r.score = rank_score[sel][sl];
            r.tag   = rank_tag[sel][sl];
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic note_mismatch(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_txn(input action_t act, input logic [SEL_W-1:0] sel,
                          input logic [SCORE_W-1:0] sc, input logic [TAG_W-1:0] tg,
                          input logic [SLOT_W-1:0] sl, input logic typed,
                          input rank_result_t typed_res);
    int gap;
    rank_result_t r;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 11) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_table_sel <= sel;
    in_score_in  <= sc;
    in_tag_in    <= tg;
    in_slot_in   <= sl;
    do @(posedge clk); while (in_stall);
    rank_apply(act, sel, sc, tg, sl, r);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 11);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_got = '{out_qualifies, out_placed_slot, out_score_out, out_tag_out};
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction q=%0d slot=%0d score=%0h tag=%0h",
                                out_qualifies, out_placed_slot, out_score_out, out_tag_out));
      end else begin
        seen_exp = pending_results.pop_front();
        if (seen_got.qualifies !== seen_exp.qualifies || seen_got.placed !== seen_exp.placed ||
            seen_got.score !== seen_exp.score || seen_got.tag !== seen_exp.tag)
          note_mismatch($sformatf(
            "exp q=%0d slot=%0d score=%0h tag=%0h, got q=%0d slot=%0d score=%0h tag=%0h",
            seen_exp.qualifies, seen_exp.placed, seen_exp.score, seen_exp.tag,
            seen_got.qualifies, seen_got.placed, seen_got.score, seen_got.tag));
      end
    end
  end

  initial begin
    action_t            act;
    logic [SEL_W-1:0]   sel;
    logic [SCORE_W-1:0] sc;
    logic [SCORE_W-1:0] base;
    int                 pick;
    for (int t = 0; t < NT; t++) begin
      for (int e = 0; e < NE; e++) begin
        rank_score[t][e] = '0;
        rank_tag[t][e]   = '0;
      end
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i])
      send_txn(DIRECTED[i].act, DIRECTED[i].sel, DIRECTED[i].score, DIRECTED[i].tag,
               DIRECTED[i].slot, DIRECTED[i].typed, DIRECTED[i].res);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 700 && n < 1000);
      pick = $urandom_range(0, 99);
      act  = pick < 40 ? ACT_INSERT : pick < 65 ? ACT_QUERY : pick < 95 ? ACT_READ : ACT_NONE;
      sel  = SEL_W'($urandom_range(0, (1 << SEL_W) - 1));
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // near a stored score: ties, just above and just below
        base = rank_score[sel][$urandom_range(0, NE - 1)];
        case ($urandom_range(0, 2))
          0: sc = base;
          1: sc = (base == SMAX) ? base : base + 1'b1;
          default: sc = (base == '0) ? base : base - 1'b1;
        endcase
      end else if (pick < 7) begin
        sc = SCORE_W'($urandom());
      end else begin
        sc = SCORE_W'($urandom_range(0, 255));
      end
      send_txn(act, sel, sc, TAG_W'($urandom()), SLOT_W'($urandom_range(0, 7)), 1'b0, '0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
